// File: rtl/core/itp_pkg.sv
package itp_pkg;

	// Operator stack and front-to-back queue sizes
	localparam int STACK_DEPTH = 16;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Token kinds
	localparam logic [3:0] KIND_ID     = 4'd0;
	localparam logic [3:0] KIND_LIT    = 4'd1;
	localparam logic [3:0] KIND_LPAREN = 4'd2;
	localparam logic [3:0] KIND_RPAREN = 4'd3;
	localparam logic [3:0] KIND_ADD    = 4'd4;
	localparam logic [3:0] KIND_SUB    = 4'd5;
	localparam logic [3:0] KIND_MUL    = 4'd6;
	localparam logic [3:0] KIND_DIV    = 4'd7;
	localparam logic [3:0] KIND_MOD    = 4'd8;
	localparam logic [3:0] KIND_SEMI   = 4'd9;
	localparam logic [3:0] KIND_ASSIGN = 4'd10;

	// Operations handed from the front end to the back end
	localparam logic [2:0] OP_PASS  = 3'd0;
	localparam logic [2:0] OP_PUSH  = 3'd1;
	localparam logic [2:0] OP_CLOSE = 3'd2;
	localparam logic [2:0] OP_OPER  = 3'd3;
	localparam logic [2:0] OP_FLUSH = 3'd4;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] index;
		logic [2:0]  prio;
		logic [15:0] line;
	} tok_t;

	typedef struct packed {
		logic [2:0] op;
		logic       other;
		tok_t       tok;
	} op_t;

	typedef struct packed {
		tok_t tok;
		logic other;
		logic ovf;
	} res_t;

endpackage

// File: rtl/core/itp_front.sv
module itp_front
	import itp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        token_valid,
	output logic        token_stall,
	input  logic [3:0]  token_kind,
	input  logic [15:0] table_index,
	input  logic [2:0]  priority_req,
	input  logic [15:0] line_number,
	input  logic        other_token,
	input  logic        q_full,
	output logic        q_push,
	output op_t         q_op
);

	logic in_expr_q;
	logic xfer;
	logic open_expr;
	logic close_expr;

	assign token_stall = q_full;
	assign xfer        = token_valid && !q_full;
	assign q_push      = xfer;

	// Classify the token against the current mode
	always_comb begin
		q_op.tok.kind  = token_kind;
		q_op.tok.index = table_index;
		q_op.tok.prio  = priority_req;
		q_op.tok.line  = line_number;
		q_op.other     = other_token;
		q_op.op        = OP_PASS;
		open_expr      = 1'b0;
		close_expr     = 1'b0;
		if (other_token) begin
			q_op.op = OP_PASS;
		end else if (!in_expr_q) begin
			q_op.op   = OP_PASS;
			open_expr = (token_kind == KIND_ASSIGN);
		end else begin
			unique case (token_kind) inside
				KIND_ID, KIND_LIT: q_op.op = OP_PASS;
				KIND_LPAREN:       q_op.op = OP_PUSH;
				KIND_RPAREN:       q_op.op = OP_CLOSE;
				KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD: q_op.op = OP_OPER;
				KIND_SEMI: begin
					q_op.op    = OP_FLUSH;
					close_expr = 1'b1;
				end
				default:           q_op.op = OP_PASS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_expr_q <= 1'b0;
		end else if (xfer) begin
			if (open_expr) begin
				in_expr_q <= 1'b1;
			end else if (close_expr) begin
				in_expr_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/itp_queue.sv
module itp_queue
	import itp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	output logic valid,
	output op_t  head,
	input  logic pop
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/itp_back.sv
module itp_back
	import itp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  op_t  q_op,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_res,
	output logic out_last
);

	tok_t              stack_q [STACK_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic              busy_q;
	logic              fin_q;
	op_t               cur_q;
	res_t              pend_q;
	logic              pend_valid_q;
	res_t              out_q;
	logic              out_valid_q;
	logic              out_last_q;

	logic [PTR_W-1:0]  top_ptr;
	tok_t              top;
	logic              has_top;
	logic              full;
	logic              top_binds;
	logic              out_free;
	logic              slot_ok;

	logic              gen;
	logic              done;
	logic              pop_emit;
	logic              drop_top;
	logic              push_tok;
	logic              set_fin;
	res_t              gen_res;
	logic              gen_fire;
	logic              done_fire;
	logic              fetch;
	logic              load_out;

	assign top_ptr   = count_q[PTR_W-1:0] - PTR_W'(1);
	assign top       = stack_q[top_ptr];
	assign has_top   = (count_q != '0);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign top_binds = has_top && (top.kind != KIND_LPAREN) && (top.prio >= cur_q.tok.prio);
	assign out_free  = !out_valid_q || !out_stall;
	assign slot_ok   = !pend_valid_q || out_free;

	// One step of the current operation: either produce a result or finish
	always_comb begin
		gen      = 1'b0;
		done     = 1'b0;
		pop_emit = 1'b0;
		drop_top = 1'b0;
		push_tok = 1'b0;
		set_fin  = 1'b0;
		gen_res  = '{tok: cur_q.tok, other: 1'b0, ovf: 1'b0};
		unique case (cur_q.op)
			OP_PASS: begin
				if (!fin_q) begin
					gen           = 1'b1;
					set_fin       = 1'b1;
					gen_res.other = cur_q.other;
				end else begin
					done = 1'b1;
				end
			end
			OP_PUSH, OP_OPER: begin
				if (cur_q.op == OP_OPER && top_binds) begin
					gen      = 1'b1;
					pop_emit = 1'b1;
					gen_res  = '{tok: top, other: 1'b0, ovf: 1'b0};
				end else if (!fin_q && full) begin
					gen         = 1'b1;
					set_fin     = 1'b1;
					gen_res.ovf = 1'b1;
				end else begin
					done     = 1'b1;
					push_tok = !fin_q;
				end
			end
			OP_CLOSE: begin
				if (has_top && top.kind != KIND_LPAREN) begin
					gen      = 1'b1;
					pop_emit = 1'b1;
					gen_res  = '{tok: top, other: 1'b0, ovf: 1'b0};
				end else begin
					done     = 1'b1;
					drop_top = has_top;
				end
			end
			OP_FLUSH: begin
				if (has_top) begin
					gen      = 1'b1;
					pop_emit = 1'b1;
					gen_res  = '{tok: top, other: 1'b0, ovf: 1'b0};
				end else if (!fin_q) begin
					gen     = 1'b1;
					set_fin = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			default: done = 1'b1;
		endcase
	end

	assign gen_fire  = busy_q && slot_ok && gen;
	assign done_fire = busy_q && slot_ok && done;
	assign fetch     = q_valid && (!busy_q || done_fire);
	assign q_pop     = fetch;
	assign load_out  = (gen_fire || done_fire) && pend_valid_q;

	always_ff @(posedge clk) begin
		if (done_fire && push_tok) begin
			stack_q[count_q[PTR_W-1:0]] <= cur_q.tok;
		end
		if (fetch) begin
			cur_q <= q_op;
		end
		if (gen_fire) begin
			pend_q <= gen_res;
		end
		if (load_out) begin
			out_q      <= pend_q;
			out_last_q <= done_fire;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			busy_q       <= 1'b0;
			fin_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((gen_fire && pop_emit) || (done_fire && drop_top)) begin
				count_q <= count_q - CNT_W'(1);
			end else if (done_fire && push_tok) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (fetch) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
			end else begin
				if (done_fire) begin
					busy_q <= 1'b0;
				end
				if (gen_fire && set_fin) begin
					fin_q <= 1'b1;
				end
			end

			if (gen_fire) begin
				pend_valid_q <= 1'b1;
			end else if (done_fire) begin
				pend_valid_q <= 1'b0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

// File: rtl/core/infix_to_postfix_converter_core.sv
// Infix-to-postfix token converter (shunting-yard).
// Token channel: token_valid / token_stall with the token fields; a transfer
// happens on a rising edge with token_valid high and token_stall low.
// Result channel: result_valid / result_stall with the emitted token fields,
// last_of_run marking the final result a token causes and overflow_flag the
// result that reports a token dropped on a full operator stack.
// Outside an expression tokens pass through; an assign token opens one
// and a semicolon flushes the operator stack and closes it.
// The front end classifies each token and writes it into a two-entry queue;
// the back end runs the operator stack, one pop or emit per cycle while
// the result path is not stalled. It works on one token at a time, emitting
// its results in turn and finishing it before it fetches the next one, while
// the queue lets the front end accept tokens until it fills.
// Reset clears the mode, the stack count, the queue and all valid flags;
// stack contents are not cleared and need no clearing pass.
// A stalled result holds in the output register; the back end keeps one more
// result pending and then halts, and the queue fills and raises token_stall.
module infix_to_postfix_converter_core
	import itp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        token_valid,
	output logic        token_stall,
	input  logic [3:0]  token_kind,
	input  logic [15:0] table_index,
	input  logic [2:0]  priority_req,
	input  logic [15:0] line_number,
	input  logic        other_token,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  out_kind,
	output logic [15:0] out_index,
	output logic [2:0]  out_priority,
	output logic [15:0] out_line,
	output logic        out_other,
	output logic        last_of_run,
	output logic        overflow_flag
);

	logic q_full;
	logic q_push;
	op_t  q_in;
	logic q_valid;
	op_t  q_head;
	logic q_pop;
	res_t res;

	// Classify tokens and track expression mode
	itp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.table_index  (table_index),
		.priority_req (priority_req),
		.line_number  (line_number),
		.other_token  (other_token),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_op         (q_in)
	);

	// Decouple classification from stack work
	itp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_in),
		.full    (q_full),
		.valid   (q_valid),
		.head    (q_head),
		.pop     (q_pop)
	);

	// Run the operator stack and drive the result register
	itp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_head),
		.q_pop     (q_pop),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_res   (res),
		.out_last  (last_of_run)
	);

	assign out_kind      = res.tok.kind;
	assign out_index     = res.tok.index;
	assign out_priority  = res.tok.prio;
	assign out_line      = res.tok.line;
	assign out_other     = res.other;
	assign overflow_flag = res.ovf;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import itp_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int IDLE_LIMIT  = 2000;            // cycles without any transfer
	localparam int TAIL_CYCLES = STACK_DEPTH + 16;
	localparam int RANDOM_ITEMS = 150;

	// One token as the lexer hands it over, plus driver-side controls:
	// calm drops the gap after this token, hold marks a pause point.
	typedef struct {
		logic [3:0]  kind;
		logic [15:0] index;
		logic [2:0]  prio;
		logic [15:0] line;
		logic        other;
		bit          calm;
		bit          hold;
	} lexeme_t;

	// One postfix token as the converter should emit it
	typedef struct packed {
		tok_t tok;
		logic other;
		logic last;
		logic ovf;
	} emitted_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        token_valid = 1'b0;
	logic        token_stall;
	logic [3:0]  token_kind = '0;
	logic [15:0] table_index = '0;
	logic [2:0]  priority_req = '0;
	logic [15:0] line_number = '0;
	logic        other_token = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [3:0]  out_kind;
	logic [15:0] out_index;
	logic [2:0]  out_priority;
	logic [15:0] out_line;
	logic        out_other;
	logic        last_of_run;
	logic        overflow_flag;

	// Stimulus and expectation stores
	lexeme_t  pending[$];
	emitted_t postfix_q[$];

	// Shadow copy of the converter state
	tok_t op_stack[STACK_DEPTH];
	int   op_depth = 0;
	bit   expr_open = 1'b0;

	int       errors = 0;
	int       gap_left = 0;
	int       stall_left = 0;
	int       quiet_left = 0;
	int       idle_cycles = 0;
	int       start_size;
	bit       calm_run = 1'b0;
	bit       hold_placed;
	bit       drive_next;
	lexeme_t  head;
	emitted_t want;

	infix_to_postfix_converter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.table_index  (table_index),
		.priority_req (priority_req),
		.line_number  (line_number),
		.other_token  (other_token),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_kind     (out_kind),
		.out_index    (out_index),
		.out_priority (out_priority),
		.out_line     (out_line),
		.out_other    (out_other),
		.last_of_run  (last_of_run),
		.overflow_flag(overflow_flag)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Shunting-yard predictor
	// ------------------------------------------------------------------

	function automatic void emit_token(input tok_t t, input logic other, input logic ovf);
		emitted_t e;
		e.tok   = t;
		e.other = other;
		e.last  = 1'b0;
		e.ovf   = ovf;
		postfix_q.push_back(e);
	endfunction

	// Push onto the operator stack; a full stack drops the token and
	// reports it back with the overflow mark.
	function automatic void stack_push(input tok_t t);
		if (op_depth >= STACK_DEPTH) begin
			emit_token(t, 1'b0, 1'b1);
		end else begin
			op_stack[op_depth] = t;
			op_depth++;
		end
	endfunction

	// Advance the shadow state by one accepted token and queue every
	// postfix token it causes, marking the last one.
	function automatic void convert_lexeme(input lexeme_t lx);
		tok_t t;
		int   base;
		t.kind  = lx.kind;
		t.index = lx.index;
		t.prio  = lx.prio;
		t.line  = lx.line;
		base = postfix_q.size();
		if (lx.other) begin
			// foreign tokens pass untouched and never change the mode
			emit_token(t, 1'b1, 1'b0);
		end else if (!expr_open) begin
			emit_token(t, 1'b0, 1'b0);
			if (t.kind == KIND_ASSIGN)
				expr_open = 1'b1;
		end else begin
			case (t.kind)
				KIND_ID, KIND_LIT: begin
					emit_token(t, 1'b0, 1'b0);
				end
				KIND_LPAREN: begin
					stack_push(t);
				end
				KIND_RPAREN: begin
					// unwind to the matching '(' or drain the whole stack
					while (op_depth > 0) begin
						op_depth--;
						if (op_stack[op_depth].kind == KIND_LPAREN)
							break;
						emit_token(op_stack[op_depth], 1'b0, 1'b0);
					end
				end
				KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD: begin
					// pop everything that binds at least as tightly
					while (op_depth > 0 && op_stack[op_depth - 1].kind != KIND_LPAREN &&
					       op_stack[op_depth - 1].prio >= t.prio) begin
						op_depth--;
						emit_token(op_stack[op_depth], 1'b0, 1'b0);
					end
					stack_push(t);
				end
				KIND_SEMI: begin
					while (op_depth > 0) begin
						op_depth--;
						emit_token(op_stack[op_depth], 1'b0, 1'b0);
					end
					emit_token(t, 1'b0, 1'b0);
					expr_open = 1'b0;
				end
				default: begin
					// unknown kinds pass and leave the expression open
					emit_token(t, 1'b0, 1'b0);
				end
			endcase
		end
		if (postfix_q.size() > base)
			postfix_q[postfix_q.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short gaps, now and then a long one
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void queue_token(input logic [3:0] kind, input logic [2:0] prio,
	                                    input logic other, input logic [15:0] index,
	                                    input logic [15:0] line);
		lexeme_t lx;
		lx.kind  = kind;
		lx.index = index;
		lx.prio  = prio;
		lx.line  = line;
		lx.other = other;
		lx.calm  = calm_run;
		lx.hold  = 1'b0;
		pending.push_back(lx);
	endfunction

	// Pause point: the driver holds here until every expected result is in
	function automatic void queue_hold();
		lexeme_t lx;
		lx = '{default: '0};
		lx.hold = 1'b1;
		pending.push_back(lx);
	endfunction

	function automatic void queue_operand();
		queue_token($urandom_range(0, 1) ? KIND_ID : KIND_LIT, 3'($urandom_range(0, 7)), 1'b0,
		            16'($urandom), 16'($urandom));
	endfunction

	// One statement: mostly well-formed assignments with random content,
	// some deep paren runs that fill the stack, some noise and breakage.
	function automatic void queue_statement();
		int r;
		int operands;
		int open_parens;
		r = $urandom_range(0, 99);
		calm_run = ($urandom_range(0, 4) == 0);
		if (r < 15) begin
			repeat ($urandom_range(1, 5))
				queue_token(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
				            $urandom_range(0, 4) == 0, 16'($urandom), 16'($urandom));
			return;
		end
		queue_token(KIND_ASSIGN, 3'($urandom_range(0, 7)), 1'b0, 16'($urandom), 16'($urandom));
		if (r < 30) begin
			repeat ($urandom_range(14, 20)) begin
				if ($urandom_range(0, 3) == 0)
					queue_operand();
				else
					queue_token(KIND_LPAREN, 3'($urandom_range(0, 7)), 1'b0,
					            16'($urandom), 16'($urandom));
			end
		end else begin
			operands = $urandom_range(1, 7);
			open_parens = 0;
			for (int i = 0; i < operands; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					queue_token(KIND_LPAREN, 3'($urandom_range(0, 7)), 1'b0,
					            16'($urandom), 16'($urandom));
					open_parens++;
				end
				queue_operand();
				if ($urandom_range(0, 24) == 0)
					queue_token(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), 1'b1,
					            16'($urandom), 16'($urandom));
				if (open_parens > 0 && $urandom_range(0, 2) == 0) begin
					queue_token(KIND_RPAREN, 3'($urandom_range(0, 7)), 1'b0,
					            16'($urandom), 16'($urandom));
					open_parens--;
				end
				if (i < operands - 1)
					queue_token(4'($urandom_range(KIND_ADD, KIND_MOD)),
					            3'($urandom_range(0, 7)), 1'b0, 16'($urandom), 16'($urandom));
			end
			// close what is open, sometimes one too few or one too many
			if ($urandom_range(0, 9) == 0)
				open_parens = open_parens + ($urandom_range(0, 1) ? 1 : -1);
			repeat (open_parens)
				queue_token(KIND_RPAREN, 3'($urandom_range(0, 7)), 1'b0,
				            16'($urandom), 16'($urandom));
		end
		if ($urandom_range(0, 19) != 0)
			queue_token(KIND_SEMI, 3'($urandom_range(0, 7)), 1'b0, 16'($urandom), 16'($urandom));
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
	                           input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// ------------------------------------------------------------------
	// Token driver: present the head of the pending queue, hold it while
	// stalled, predict its results on transfer, then idle or advance.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid <= 1'b0;
			gap_left = 0;
		end else begin
			drive_next = token_valid;
			if (token_valid && !token_stall) begin
				convert_lexeme(pending.pop_front());
				drive_next = 1'b0;
			end
			if (!drive_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() != 0) begin
					if (pending[0].hold) begin
						// hold off until the converter has delivered everything
						if (postfix_q.size() == 0)
							pending.delete(0);
					end else begin
						head = pending[0];
						token_kind   <= head.kind;
						table_index  <= head.index;
						priority_req <= head.prio;
						line_number  <= head.line;
						other_token  <= head.other;
						drive_next = 1'b1;
						gap_left = head.calm ? 0 : pick_idle();
					end
				end
			end
			// single update per edge keeps back-to-back transfers clean
			token_valid <= drive_next;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare each transfer with the oldest expectation,
	// and throttle the converter with random stalls and quiet stretches.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
			quiet_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (postfix_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual kind %h index %h",
					         $time, out_kind, out_index);
				end else begin
					want = postfix_q.pop_front();
					check_field("out_kind", 16'(want.tok.kind), 16'(out_kind));
					check_field("out_index", want.tok.index, out_index);
					check_field("out_priority", 16'(want.tok.prio), 16'(out_priority));
					check_field("out_line", want.tok.line, out_line);
					check_field("out_other", 16'(want.other), 16'(out_other));
					check_field("last_of_run", 16'(want.last), 16'(last_of_run));
					check_field("overflow_flag", 16'(want.ovf), 16'(overflow_flag));
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (quiet_left > 0)
				quiet_left--;
			else if ($urandom_range(0, 99) < 2)
				quiet_left = $urandom_range(30, 150);
			else
				stall_left = pick_idle();
			result_stall <= (stall_left != 0);
		end
	end

	// Watchdog: drop the run when neither channel has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((token_valid && !token_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		// Directed part: pass-through outside an expression with extreme
		// fields, an unknown kind and a foreign token, then one expression
		// that walks through equal-priority pops, paren matching, foreign and
		// unknown tokens inside, an unmatched close, a close on an empty
		// stack, and the final flush.
		queue_token(KIND_ID, 3'd7, 1'b0, 16'hFFFF, 16'hFFFF);
		queue_token(4'd15, 3'd0, 1'b0, 16'h0000, 16'h0000);
		queue_token(KIND_SEMI, 3'd3, 1'b1, 16'h1234, 16'h0001);
		queue_token(KIND_ASSIGN, 3'd0, 1'b0, 16'h0001, 16'h0002);
		queue_token(KIND_ID, 3'd0, 1'b0, 16'h0010, 16'h0002);
		queue_token(KIND_ADD, 3'd2, 1'b0, 16'h0000, 16'h0002);
		queue_token(KIND_LPAREN, 3'd0, 1'b0, 16'h0000, 16'h0002);
		queue_token(KIND_LIT, 3'd0, 1'b0, 16'h0042, 16'h0002);
		queue_token(KIND_MUL, 3'd5, 1'b0, 16'h0000, 16'h0003);
		queue_token(KIND_ID, 3'd0, 1'b0, 16'h0011, 16'h0003);
		queue_token(KIND_DIV, 3'd5, 1'b0, 16'h0000, 16'h0003);
		queue_token(KIND_LIT, 3'd0, 1'b0, 16'h0007, 16'h0003);
		queue_token(KIND_RPAREN, 3'd0, 1'b0, 16'h0000, 16'h0003);
		queue_token(KIND_SUB, 3'd2, 1'b0, 16'h0000, 16'h0004);
		queue_token(KIND_ID, 3'd1, 1'b1, 16'hABCD, 16'h0004);
		queue_token(4'd12, 3'd4, 1'b0, 16'h5555, 16'h0004);
		queue_token(KIND_ASSIGN, 3'd6, 1'b0, 16'hAAAA, 16'h0004);
		queue_token(KIND_MOD, 3'd7, 1'b0, 16'h0000, 16'h0005);
		queue_token(KIND_RPAREN, 3'd0, 1'b0, 16'h0000, 16'h0005);
		queue_token(KIND_RPAREN, 3'd0, 1'b0, 16'h0000, 16'h0005);
		queue_token(KIND_LIT, 3'd0, 1'b0, 16'hFFFF, 16'h0006);
		queue_token(KIND_SEMI, 3'd0, 1'b0, 16'h0000, 16'hFFFF);
		queue_hold();

		// Random part: open with a paren run deep enough to overflow the
		// stack, pause once more midway.
		start_size = pending.size();
		calm_run = 1'b0;
		queue_token(KIND_ASSIGN, 3'd0, 1'b0, 16'($urandom), 16'($urandom));
		repeat (STACK_DEPTH + 2)
			queue_token(KIND_LPAREN, 3'($urandom_range(0, 7)), 1'b0,
			            16'($urandom), 16'($urandom));
		queue_token(KIND_SEMI, 3'($urandom_range(0, 7)), 1'b0, 16'($urandom), 16'($urandom));
		hold_placed = 1'b0;
		while (pending.size() - start_size < RANDOM_ITEMS) begin
			queue_statement();
			if (!hold_placed && pending.size() - start_size >= RANDOM_ITEMS / 2) begin
				queue_hold();
				hold_placed = 1'b1;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// drain: every token taken, every result checked, then let it settle
		while (pending.size() != 0 || postfix_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
